// ===== rtl/psi_pkg.sv =====
// Shared types and constants for the parameter slot interpolator.
package psi_pkg;

  localparam int SLOT_W  = 6;
  localparam int BAND_W  = 5;
  localparam int VAL_W   = 32;
  localparam int Q_FRAC  = 28;
  localparam int RECIP_W = 29;
  localparam int ALPHA_W = 30;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int END_W   = SLOT_W + 1;

  localparam int ROM_DEPTH   = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int DEF_BANDS     = 28;
  localparam int DEF_MAX_SLOTS = 64;

  localparam logic [BAND_W-1:0]       NUM_BANDS_RESET = 5'd28;
  localparam logic signed [END_W-1:0] SLOT_NONE       = -7'sd1;

  // One segment of slots to interpolate for one band.
  typedef struct packed {
    logic [BAND_W-1:0]        band;
    logic [SLOT_W-1:0]        first;
    logic [SLOT_W-1:0]        hi;
    logic [VAL_W-1:0]         prev;
    logic signed [DIFF_W-1:0] diff;
    logic [RECIP_W-1:0]       recip;
  } psi_job_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } psi_qstat_t;

endpackage

// ===== rtl/psi_front.sv =====
// Request intake: band filter, segment bounds, stored band values, reciprocal lookup.
module psi_front #(
  parameter int BANDS     = psi_pkg::DEF_BANDS,
  parameter int MAX_SLOTS = psi_pkg::DEF_MAX_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [psi_pkg::BAND_W-1:0]        num_bands,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              frame_start,
  input  logic [psi_pkg::BAND_W-1:0]        band,
  input  logic [psi_pkg::SLOT_W-1:0]        end_slot,
  input  logic signed [psi_pkg::VAL_W-1:0]  new_value,
  input  psi_pkg::psi_qstat_t               q_stat,
  output logic                              q_push,
  output psi_pkg::psi_job_t                 q_job
);
  import psi_pkg::*;

  localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

  logic [RECIP_W-1:0] rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [RECIP_W-1:0] RecipVal =
      RECIP_W'(((64'd1 << Q_FRAC) + 64'((g + 1) / 2)) / 64'(g + 1));
    assign rom[g] = RecipVal;
  end

  logic [VAL_W-1:0] mem [BANDS];
  logic [BANDS-1:0] mem_vld;
  logic [VAL_W-1:0] rd_data;
  logic             rd_vld;

  logic signed [END_W-1:0] prev_end;
  logic signed [END_W-1:0] cur_end;

  logic                    accept;
  logic                    in_use;
  logic [SLOT_W-1:0]       hi;
  logic signed [END_W-1:0] lo;
  logic signed [END_W:0]   len;
  logic                    nonempty;
  logic [AW-1:0]           addr;

  logic              f1_valid;
  logic [BAND_W-1:0] f1_band;
  logic [SLOT_W-1:0] f1_first;
  logic [SLOT_W-1:0] f1_hi;
  logic [VAL_W-1:0]  f1_new;
  logic [VAL_W-1:0]  f1_prev;

  // Leave room for the item in the second stage plus the one taken now.
  assign req_stall = (int'(q_stat.count) + int'(f1_valid)) >= QUEUE_DEPTH;
  assign accept    = req_valid && !req_stall;
  assign in_use    = (band < num_bands) && (int'(band) < BANDS);
  assign addr      = AW'(band);

  always_comb begin
    if ({1'b0, end_slot} > END_W'(MAX_SLOTS - 1)) begin
      hi = SLOT_W'(MAX_SLOTS - 1);
    end else begin
      hi = end_slot;
    end
    if (frame_start) begin
      lo = SLOT_NONE;
    end else if (band == '0) begin
      lo = cur_end;
    end else begin
      lo = prev_end;
    end
    len      = $signed({2'b00, hi}) - $signed({lo[END_W-1], lo});
    nonempty = !len[END_W] && (len != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_end <= SLOT_NONE;
      cur_end  <= SLOT_NONE;
      mem_vld  <= '0;
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept && in_use && nonempty;
      if (accept && in_use) begin
        mem_vld[addr] <= 1'b1;
        if (band == '0) begin
          prev_end <= frame_start ? SLOT_NONE : cur_end;
          cur_end  <= $signed({1'b0, hi});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_use) begin
      mem[addr] <= new_value;
    end
    if (accept) begin
      rd_data  <= mem[addr];
      rd_vld   <= mem_vld[addr];
      f1_band  <= band;
      f1_first <= lo[SLOT_W-1:0] + SLOT_W'(1);
      f1_hi    <= hi;
      f1_new   <= new_value;
    end
  end

  assign f1_prev = rd_vld ? rd_data : '0;

  always_comb begin
    q_push      = f1_valid;
    q_job.band  = f1_band;
    q_job.first = f1_first;
    q_job.hi    = f1_hi;
    q_job.prev  = f1_prev;
    q_job.diff  = $signed({f1_new[VAL_W-1], f1_new}) - $signed({f1_prev[VAL_W-1], f1_prev});
    q_job.recip = rom[f1_hi - f1_first];
  end

endmodule

// ===== rtl/psi_queue.sv =====
// Small FIFO of segment jobs between intake and interpolation.
module psi_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  psi_pkg::psi_job_t   push_job,
  input  logic                pop,
  output psi_pkg::psi_job_t   head_job,
  output psi_pkg::psi_qstat_t stat
);
  import psi_pkg::*;

  psi_job_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head_job   = entries[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

endmodule

// ===== rtl/psi_back.sv =====
// Slot sequencer and shared multiply-blend pipeline with output register.
module psi_back (
  input  logic                              clk,
  input  logic                              rst,
  input  psi_pkg::psi_job_t                 head_job,
  input  psi_pkg::psi_qstat_t               q_stat,
  output logic                              q_pop,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [psi_pkg::SLOT_W-1:0]        slot,
  output logic [psi_pkg::BAND_W-1:0]        out_band,
  output logic signed [psi_pkg::VAL_W-1:0]  interp_value,
  output logic                              last
);
  import psi_pkg::*;

  logic advance;

  // Issue stage: walk the slots of one job, alpha accumulates the reciprocal.
  logic                     busy;
  logic [SLOT_W-1:0]        slot_cnt;
  logic [SLOT_W-1:0]        hi;
  logic [BAND_W-1:0]        band_q;
  logic [VAL_W-1:0]         prev_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [RECIP_W-1:0]       recip_q;
  logic [ALPHA_W-1:0]       alpha;

  // Multiply stage.
  logic                     s1_valid;
  logic [SLOT_W-1:0]        s1_slot;
  logic [BAND_W-1:0]        s1_band;
  logic                     s1_last;
  logic [VAL_W-1:0]         s1_prev;
  logic [VAL_W-1:0]         s1_prod;
  logic signed [63:0]       prod_full;

  assign advance   = !res_valid || !res_stall;
  assign q_pop     = advance && !busy && !q_stat.empty;
  assign prod_full = 64'(diff_q) * 64'($signed({1'b0, alpha}));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
      s1_valid  <= busy;
      if (busy) begin
        if (slot_cnt == hi) begin
          busy <= 1'b0;
        end
      end else if (!q_stat.empty) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        slot_cnt <= slot_cnt + SLOT_W'(1);
        alpha    <= alpha + ALPHA_W'(recip_q);
      end else begin
        slot_cnt <= head_job.first;
        hi       <= head_job.hi;
        band_q   <= head_job.band;
        prev_q   <= head_job.prev;
        diff_q   <= head_job.diff;
        recip_q  <= head_job.recip;
        alpha    <= ALPHA_W'(head_job.recip);
      end
      s1_slot      <= slot_cnt;
      s1_band      <= band_q;
      s1_last      <= (slot_cnt == hi);
      s1_prev      <= prev_q;
      s1_prod      <= prod_full[Q_FRAC+VAL_W-1:Q_FRAC];
      slot         <= s1_slot;
      out_band     <= s1_band;
      last         <= s1_last;
      // prev * 2^28 has no bits below the binary point, so only the top adds.
      interp_value <= $signed(s1_prod + s1_prev);
    end
  end

endmodule

// ===== rtl/parameter_slot_interpolator.sv =====
// Top level of the parameter slot interpolator: intake, job queue, blend engine.
//
//   channel   direction  handshake              payload
//   request   in         req_valid / req_stall  frame_start, band, end_slot, new_value
//   result    out        res_valid / res_stall  slot, out_band, interp_value, last
//   config    in         wr_en                  wr_data (num_bands)
//
// A request whose segment covers n slots occupies the blend engine for the whole segment:
// one result per cycle while res_stall is low, then a load step before the next job.
// Requests with no results use only the intake. A first result passes the intake register,
// the job queue, the issue stage, the multiply stage and the output register.
// Reset is synchronous: it clears the per-band valid bits, so stored values read as
// zero at once, and sets both end-slot registers to minus one. No clearing pass.
// res_stall freezes the whole blend pipeline; req_stall rises when the job queue
// cannot take another request.
module parameter_slot_interpolator #(
  parameter int BANDS     = psi_pkg::DEF_BANDS,
  parameter int MAX_SLOTS = psi_pkg::DEF_MAX_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [psi_pkg::BAND_W-1:0]        wr_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              frame_start,
  input  logic [psi_pkg::BAND_W-1:0]        band,
  input  logic [psi_pkg::SLOT_W-1:0]        end_slot,
  input  logic signed [psi_pkg::VAL_W-1:0]  new_value,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [psi_pkg::SLOT_W-1:0]        slot,
  output logic [psi_pkg::BAND_W-1:0]        out_band,
  output logic signed [psi_pkg::VAL_W-1:0]  interp_value,
  output logic                              last
);
  import psi_pkg::*;

  logic [BAND_W-1:0] num_bands;
  logic              q_push;
  logic              q_pop;
  psi_job_t          push_job;
  psi_job_t          head_job;
  psi_qstat_t        q_stat;

  // Hold the band count; it is to be written only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bands <= NUM_BANDS_RESET;
    end else if (wr_en) begin
      num_bands <= wr_data;
    end
  end

  // Filter the request, advance the set boundaries, swap in the band's new value.
  psi_front #(
    .BANDS     (BANDS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .num_bands   (num_bands),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .frame_start (frame_start),
    .band        (band),
    .end_slot    (end_slot),
    .new_value   (new_value),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // Decouple intake from the blend engine.
  psi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // Emit one blended value per slot.
  psi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_job     (head_job),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .slot         (slot),
    .out_band     (out_band),
    .interp_value (interp_value),
    .last         (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_stat.count != QCNT_W'(QUEUE_DEPTH)))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("job queue read while empty");

  a_unused_band_dropped: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (band >= num_bands)) |=> !q_push)
    else $error("request for an unused band produced a job");

endmodule

// ===== tb/tb_parameter_slot_interpolator.sv =====
// Self-checking testbench for the parameter slot interpolator: table-driven and random requests.
module tb_parameter_slot_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  import psi_pkg::*;

  localparam int BANDS      = DEF_BANDS;
  localparam int MAX_SLOTS  = DEF_MAX_SLOTS;
  // Cycles to let the intake settle once the last expected slot has come out.
  // Requests with no slots still pass through intake.
  localparam int SETTLE     = 24;
  // Long receiver hold-off used to back the job queue up into req_stall.
  localparam int HOLD_OFF   = 300;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The hold-off is the longest quiet stretch.
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 4;
  localparam int PHASE_REQS = 30;

  // One interpolated slot as it leaves the block.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [BAND_W-1:0] band;
    logic [VAL_W-1:0]  value;
    logic              last;
  } interp_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT,  // check against the predictor
    ROW_SINGLE,   // one slot, value equals the new value (segment of length one)
    ROW_SILENT,   // no slots at all
    ROW_CONFIG    // drain, then write num_bands from the value column
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              fs;
    logic [BAND_W-1:0] band;
    logic [SLOT_W-1:0] end_slot;
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  expect_value;
  } stim_row_t;

  localparam int N_DIRECTED = 23;

  // Directed requests, walked in order right after reset (num_bands starts at 28).
  stim_row_t directed_rows [N_DIRECTED] = '{
    // frame start, single-slot segments: the blend returns the new value unchanged
    '{ROW_SINGLE,  1'b1, 5'd0,  6'd0,  32'h7fff_ffff, 32'h7fff_ffff},
    '{ROW_SINGLE,  1'b1, 5'd1,  6'd0,  32'h8000_0000, 32'h8000_0000},
    '{ROW_SINGLE,  1'b1, 5'd27, 6'd0,  32'hffff_ffff, 32'hffff_ffff},
    // bands past the last physical band are dropped
    '{ROW_SILENT,  1'b0, 5'd28, 6'd5,  32'h0000_0123, 32'h0},
    '{ROW_SILENT,  1'b1, 5'd31, 6'd63, 32'hffff_ffff, 32'h0},
    // end slot equal to the previous one: nothing out, stored value replaced
    '{ROW_SILENT,  1'b0, 5'd0,  6'd0,  32'h1234_5678, 32'h0},
    '{ROW_SILENT,  1'b0, 5'd1,  6'd0,  32'h0000_abcd, 32'h0},
    // long segments from the replaced values, sign extremes on both ends
    '{ROW_PREDICT, 1'b0, 5'd0,  6'd63, 32'h8000_0000, 32'h0},
    '{ROW_PREDICT, 1'b0, 5'd1,  6'd63, 32'h7fff_ffff, 32'h0},
    '{ROW_PREDICT, 1'b0, 5'd27, 6'd63, 32'h8000_0000, 32'h0},
    // full 64-slot segments
    '{ROW_PREDICT, 1'b1, 5'd0,  6'd63, 32'h7fff_ffff, 32'h0},
    '{ROW_PREDICT, 1'b1, 5'd27, 6'd63, 32'h7fff_ffff, 32'h0},
    // end slot below the previous end: empty segment
    '{ROW_SILENT,  1'b0, 5'd0,  6'd10, 32'h0000_0000, 32'h0},
    '{ROW_SILENT,  1'b0, 5'd1,  6'd20, 32'h0000_0000, 32'h0},
    // short sets; band 2 runs to its own end slot
    '{ROW_PREDICT, 1'b1, 5'd0,  6'd5,  32'h4000_0000, 32'h0},
    '{ROW_PREDICT, 1'b0, 5'd0,  6'd9,  32'hc000_0000, 32'h0},
    '{ROW_PREDICT, 1'b0, 5'd5,  6'd9,  32'hffff_ffff, 32'h0},
    '{ROW_PREDICT, 1'b0, 5'd2,  6'd30, 32'h0000_0001, 32'h0},
    // one band in use: band 1 is out of use
    '{ROW_CONFIG,  1'b0, 5'd0,  6'd0,  32'd1,         32'h0},
    '{ROW_SILENT,  1'b1, 5'd1,  6'd0,  32'h5555_5555, 32'h0},
    '{ROW_SINGLE,  1'b1, 5'd0,  6'd0,  32'haaaa_aaaa, 32'haaaa_aaaa},
    '{ROW_PREDICT, 1'b0, 5'd0,  6'd40, 32'h0000_0000, 32'h0},
    '{ROW_CONFIG,  1'b0, 5'd0,  6'd0,  32'd28,        32'h0}
  };

  logic                      clk;
  logic                      rst          = 1'b1;
  logic                      wr_en        = 1'b0;
  logic [BAND_W-1:0]         wr_data      = '0;
  logic                      req_valid    = 1'b0;
  logic                      req_stall;
  logic                      frame_start  = 1'b0;
  logic [BAND_W-1:0]         band         = '0;
  logic [SLOT_W-1:0]         end_slot     = '0;
  logic signed [VAL_W-1:0]   new_value    = '0;
  logic                      res_valid;
  logic                      res_stall    = 1'b0;
  logic [SLOT_W-1:0]         slot;
  logic [BAND_W-1:0]         out_band;
  logic signed [VAL_W-1:0]   interp_value;
  logic                      last;

  // Predictor state: stored band values, set boundaries, band count.
  logic signed [VAL_W-1:0]   held_value [BANDS];
  int                        seg_prev_end;
  int                        seg_cur_end;
  logic [BAND_W-1:0]         bands_in_use;

  interp_t                   fresh_slots[$];    // slots caused by the latest request
  interp_t                   awaited_slots[$];  // slots still to come out, oldest first

  int                        fails = 0;
  int                        idle_cycles = 0;
  int                        burst_left = 0;
  int                        phase_reqs = 0;
  bit                        hold_go = 1'b0;

  parameter_slot_interpolator #(
    .BANDS    (BANDS),
    .MAX_SLOTS(MAX_SLOTS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_data     (wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .frame_start (frame_start),
    .band        (band),
    .end_slot    (end_slot),
    .new_value   (new_value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .slot        (slot),
    .out_band    (out_band),
    .interp_value(interp_value),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out every slot one accepted request causes and advance the predictor state.
  // Leaves the slots in fresh_slots.
  function automatic void blend_request(input logic fs, input logic [BAND_W-1:0] b,
                                        input logic [SLOT_W-1:0] e,
                                        input logic signed [VAL_W-1:0] v);
    longint  one_q;
    longint  prev_v;
    longint  new_v;
    longint  recip;
    longint  alpha;
    longint  acc;
    int      lo;
    int      hi;
    int      len;
    interp_t r;
    fresh_slots.delete();
    // Drop requests for bands out of use: no slots, no state change.
    if (b >= bands_in_use || b >= BANDS) return;
    hi = e;
    // Clamp the end slot to the last slot there is.
    if (hi > MAX_SLOTS - 1) hi = MAX_SLOTS - 1;
    // Band 0 opens a new parameter set.
    if (b == 0) begin
      seg_prev_end = fs ? -1 : seg_cur_end;
      seg_cur_end  = hi;
    end
    lo = fs ? -1 : seg_prev_end;
    // The stored value is replaced even when the segment turns out empty.
    prev_v = held_value[b];
    new_v  = v;
    held_value[b] = v;
    len = hi - lo;
    if (len <= 0 || len > MAX_SLOTS) return;
    one_q = longint'(1) <<< Q_FRAC;
    // Reciprocal of the segment length in Q28, half rounding up.
    recip = (one_q + len / 2) / len;
    for (int s = lo + 1; s <= hi; s++) begin
      alpha   = recip * (s - lo);
      acc     = prev_v * (one_q - alpha) + new_v * alpha;
      r.slot  = SLOT_W'(s);
      r.band  = b;
      r.value = VAL_W'(acc >>> Q_FRAC);
      r.last  = (s == hi);
      fresh_slots.push_back(r);
    end
  endfunction

  // Offer one request and hold it until the block takes it. The sender runs in
  // bursts; drop valid for a random gap, sometimes none, whenever a burst runs out.
  task automatic present(input logic fs, input logic [BAND_W-1:0] b,
                         input logic [SLOT_W-1:0] e, input logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_valid   <= 1'b1;
    frame_start <= fs;
    band        <= b;
    end_slot    <= e;
    new_value   <= v;
    // Accepted at the first edge that sees valid with no stall.
    do @(posedge clk); while (req_stall);
    if (b < bands_in_use && b < BANDS) phase_reqs++;
  endtask

  // Send a request and queue the predictor's slots for it.
  task automatic send_predicted(input logic fs, input logic [BAND_W-1:0] b,
                                input logic [SLOT_W-1:0] e, input logic [VAL_W-1:0] v);
    present(fs, b, e, v);
    blend_request(fs, b, e, v);
    foreach (fresh_slots[i]) awaited_slots.push_back(fresh_slots[i]);
  endtask

  // Stop offering, wait out every expected slot, then let empty requests clear intake.
  task automatic drain();
    req_valid <= 1'b0;
    while (awaited_slots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write num_bands; call only while the block is idle.
  task automatic set_band_count(input logic [BAND_W-1:0] n);
    wr_en   <= 1'b1;
    wr_data <= n;
    @(posedge clk);
    wr_en <= 1'b0;
    bands_in_use = n;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Noise: any field combination, including bands out of use and stray frame starts.
  task automatic send_noise();
    send_predicted(1'($urandom_range(0, 1)), BAND_W'($urandom_range(0, 31)),
                   SLOT_W'($urandom_range(0, 63)), pick_value());
  endtask

  // One frame of well-formed parameter sets: band 0 first, then every band in use,
  // end slots rising. Some sets are broken (bands dropped, stray end slots) and
  // noise requests are mixed in.
  task automatic run_frame(input int nb);
    int  sets;
    int  prev_end;
    int  set_end;
    int  e;
    bit  broken;
    sets     = $urandom_range(1, 4);
    prev_end = -1;
    for (int s = 0; s < sets; s++) begin
      if (prev_end >= MAX_SLOTS - 1 || phase_reqs >= PHASE_REQS) break;
      set_end = prev_end + $urandom_range(1, 24);
      if (set_end > MAX_SLOTS - 1) set_end = MAX_SLOTS - 1;
      broken = ($urandom_range(0, 7) == 0);
      for (int b = 0; b < nb; b++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        if (broken && $urandom_range(0, 3) == 0) continue;
        e = (broken && $urandom_range(0, 2) == 0) ? $urandom_range(0, 63) : set_end;
        send_predicted(s == 0, BAND_W'(b), SLOT_W'(e), pick_value());
      end
      prev_end = set_end;
    end
  endtask

  // Compare one field and count a mismatch.
  function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endfunction

  // Result side: compare every accepted slot with the oldest expectation.
  always @(posedge clk) begin
    interp_t want;
    if (!rst && res_valid && !res_stall) begin
      if (awaited_slots.size() == 0) begin
        $error("unexpected slot %0d band %0d value %0h", slot, out_band, interp_value);
        fails++;
      end else begin
        want = awaited_slots.pop_front();
        check_field("slot", want.slot, slot);
        check_field("out_band", want.band, out_band);
        check_field("interp_value", want.value, interp_value);
        check_field("last", want.last, last);
      end
    end
  end

  // Watchdog: give up after too many cycles with no handshake anywhere.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_parameter_slot_interpolator NOT OK");
        $finish;
      end
    end
  end

  // Receiver: stretches of no stall, light stall and heavy stall, plus one long
  // hold-off once the random part starts so the job queue fills and req_stall rises.
  initial begin
    int  mode;
    int  run;
    bit  held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        repeat (HOLD_OFF) begin
          res_stall <= 1'b1;
          @(posedge clk);
        end
      end
      mode = $urandom_range(0, 2);
      run  = $urandom_range(4, 40);
      repeat (run) begin
        case (mode)
          0:       res_stall <= 1'b0;
          1:       res_stall <= ($urandom_range(0, 3) == 0);
          default: res_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus: reset, directed table, then random phases at several band counts.
  initial begin
    int phase_bands [PHASES];
    interp_t one;
    foreach (held_value[i]) held_value[i] = '0;
    seg_prev_end = -1;
    seg_cur_end  = -1;
    bands_in_use = NUM_BANDS_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CONFIG: begin
          drain();
          set_band_count(BAND_W'(directed_rows[i].value));
        end
        ROW_PREDICT: begin
          send_predicted(directed_rows[i].fs, directed_rows[i].band,
                         directed_rows[i].end_slot, directed_rows[i].value);
        end
        default: begin
          present(directed_rows[i].fs, directed_rows[i].band,
                  directed_rows[i].end_slot, directed_rows[i].value);
          // Keep the predictor in step; the typed row decides what is expected.
          blend_request(directed_rows[i].fs, directed_rows[i].band,
                        directed_rows[i].end_slot, directed_rows[i].value);
          if (directed_rows[i].kind == ROW_SINGLE) begin
            one.slot  = directed_rows[i].end_slot;
            one.band  = directed_rows[i].band;
            one.value = directed_rows[i].expect_value;
            one.last  = 1'b1;
            awaited_slots.push_back(one);
          end
        end
      endcase
    end

    // Start with all bands so the hold-off backs up a busy queue; cover one band.
    phase_bands[0] = 28;
    phase_bands[1] = 1;
    phase_bands[2] = $urandom_range(2, 9);
    phase_bands[3] = $urandom_range(10, 27);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_band_count(BAND_W'(phase_bands[p]));
      if (p == 0) hold_go = 1'b1;
      phase_reqs = 0;
      while (phase_reqs < PHASE_REQS) run_frame(phase_bands[p]);
    end

    drain();
    if (fails == 0) begin
      $display("tb_parameter_slot_interpolator OK");
    end else begin
      $display("tb_parameter_slot_interpolator NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/psi_pkg.sv
rtl/psi_front.sv
rtl/psi_queue.sv
rtl/psi_back.sv
rtl/parameter_slot_interpolator.sv
tb/tb_parameter_slot_interpolator.sv
